FILE: rtl/scu_pkg.sv
package scu_pkg;

	// Lexer modes
	localparam logic [3:0] M_INIT  = 4'd0;
	localparam logic [3:0] M_ERROR = 4'd1;
	localparam logic [3:0] M_DONE  = 4'd2;
	localparam logic [3:0] M_WORD  = 4'd3;
	localparam logic [3:0] M_WESC  = 4'd4;
	localparam logic [3:0] M_STR   = 4'd5;
	localparam logic [3:0] M_SESC  = 4'd6;
	localparam logic [3:0] M_PIPE  = 4'd7;
	localparam logic [3:0] M_PIPE2 = 4'd8;
	localparam logic [3:0] M_AMP   = 4'd9;
	localparam logic [3:0] M_AMP2  = 4'd10;
	localparam logic [3:0] M_GT    = 4'd11;
	localparam logic [3:0] M_GT2   = 4'd12;

	// Result kinds
	localparam logic [1:0] K_CHAR = 2'd0;
	localparam logic [1:0] K_END  = 2'd1;
	localparam logic [1:0] K_LINE = 2'd2;
	localparam logic [1:0] K_ERR  = 2'd3;

	// Token types
	localparam logic [3:0] T_WORD  = 4'd0;
	localparam logic [3:0] T_LT    = 4'd1;
	localparam logic [3:0] T_SEMI  = 4'd2;
	localparam logic [3:0] T_PAREN = 4'd3;
	localparam logic [3:0] T_PIPE  = 4'd4;
	localparam logic [3:0] T_OR    = 4'd5;
	localparam logic [3:0] T_BG    = 4'd6;
	localparam logic [3:0] T_AND   = 4'd7;
	localparam logic [3:0] T_GT    = 4'd8;
	localparam logic [3:0] T_GT2   = 4'd9;

	// Error codes
	localparam logic [1:0] E_NONE   = 2'd0;
	localparam logic [1:0] E_TRIPLE = 2'd1;
	localparam logic [1:0] E_ESCAPE = 2'd2;
	localparam logic [1:0] E_QUOTE  = 2'd3;

	// Characters
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int MAX_RES = 3;

	// token_char in the lowest bits as on m_tdata; kind leaves on m_tuser
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] error_code;
		logic [3:0] token_type;
		logic [7:0] token_char;
	} result_t;

	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            count;
	} step_t;

	function automatic result_t mk_char(logic [7:0] c);
		result_t r;
		r = '0;
		r.kind = K_CHAR;
		r.token_char = c;
		return r;
	endfunction

	function automatic result_t mk_end(logic [3:0] t);
		result_t r;
		r = '0;
		r.kind = K_END;
		r.token_type = t;
		return r;
	endfunction

	function automatic result_t mk_err(logic [1:0] e);
		result_t r;
		r = '0;
		r.kind = K_ERR;
		r.error_code = e;
		return r;
	endfunction

	function automatic result_t mk_line();
		result_t r;
		r = '0;
		r.kind = K_LINE;
		return r;
	endfunction

endpackage

FILE: rtl/shell_command_tokenizer_unit.sv
// Shell-style command-line tokenizer, one byte per input word.
// Input stream s_*: s_tdata = the byte, s_tuser = func (1 clears the lexer).
// Output stream m_*: one word per result; m_tuser holds the kind, m_tdata holds
// token_char, token_type and error_code, and m_tlast marks the final result caused
// by one input byte.
// Each byte yields zero to three results: appended characters, token ends with the
// token type, a line-complete marker on newline, or an error. After an error or a
// completed line, bytes are dropped silently until a clear word arrives.
// Path: a byte accepted on s_* enters the input register, then passes through the
// combinational lexer into the result queue, whose head drives m_*; while the queue
// is busy, the byte holds in the input register until the queue can take its results.
// Throughput: the single result port drains one result per cycle while m_tready is
// high, so a held byte advances only as the final result of the one before leaves.
// The input register takes a new byte whenever the held one moves on, so the next
// byte waits in place while results drain.
// Reset: lexer returns to the initial mode, the input register and result queue empty.
// When the receiver stalls, results hold on m_* and input backs up through s_tready.
module shell_command_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_value
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] token_char, [11:8] token_type,
	                               // [13:12] error_code, [15:14] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	logic           valid_s1;
	logic           func_s1;
	logic [7:0]     char_s1;
	logic           free;
	logic           fire;
	scu_pkg::step_t step;

	// advance the held byte once the queue can take its results
	assign fire     = valid_s1 && free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	scu_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (func_s1),
		.char_value (char_s1),
		.step       (step)
	);

	scu_result_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.step     (step),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(char_s1) && $stable(func_s1))
		else $error("held input byte lost or changed");

endmodule

FILE: rtl/scu_lexer.sv
module scu_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                func,
	input  logic [7:0]          char_value,
	output scu_pkg::step_t      step
);

	logic [3:0] mode_q;
	logic [1:0] err_q;
	logic [3:0] mode_n;
	logic [1:0] err_n;
	logic       redo;
	logic [1:0] cnt;
	scu_pkg::result_t [scu_pkg::MAX_RES-1:0] res;

	always_comb begin
		res    = '0;
		cnt    = 2'd0;
		mode_n = mode_q;
		err_n  = err_q;
		redo   = 1'b0;
		if (func) begin
			mode_n = scu_pkg::M_INIT;
			err_n  = scu_pkg::E_NONE;
		end else begin
			unique case (mode_q)
				scu_pkg::M_INIT: begin
					redo = 1'b1;
				end
				scu_pkg::M_WORD: begin
					case (char_value) inside
						scu_pkg::CH_BSLASH: mode_n = scu_pkg::M_WESC;
						scu_pkg::CH_DQUOTE: mode_n = scu_pkg::M_STR;
						scu_pkg::CH_NL, scu_pkg::CH_SPACE, scu_pkg::CH_TAB, scu_pkg::CH_LT,
						scu_pkg::CH_SEMI, scu_pkg::CH_LPAREN, scu_pkg::CH_RPAREN,
						scu_pkg::CH_PIPE, scu_pkg::CH_AMP, scu_pkg::CH_GT: begin
							mode_n   = scu_pkg::M_INIT;
							res[cnt] = scu_pkg::mk_end(scu_pkg::T_WORD);
							cnt      = cnt + 2'd1;
							redo     = 1'b1;
						end
						default: begin
							res[cnt] = scu_pkg::mk_char(char_value);
							cnt      = cnt + 2'd1;
						end
					endcase
				end
				scu_pkg::M_WESC, scu_pkg::M_SESC: begin
					if (char_value == scu_pkg::CH_BSLASH || char_value == scu_pkg::CH_DQUOTE) begin
						mode_n   = (mode_q == scu_pkg::M_WESC) ? scu_pkg::M_WORD : scu_pkg::M_STR;
						res[cnt] = scu_pkg::mk_char(char_value);
						cnt      = cnt + 2'd1;
					end else begin
						mode_n   = scu_pkg::M_ERROR;
						err_n    = scu_pkg::E_ESCAPE;
						res[cnt] = scu_pkg::mk_err(scu_pkg::E_ESCAPE);
						cnt      = cnt + 2'd1;
					end
				end
				scu_pkg::M_STR: begin
					case (char_value)
						scu_pkg::CH_BSLASH: mode_n = scu_pkg::M_SESC;
						scu_pkg::CH_DQUOTE: mode_n = scu_pkg::M_WORD;
						scu_pkg::CH_NL: begin
							mode_n   = scu_pkg::M_ERROR;
							err_n    = scu_pkg::E_QUOTE;
							res[cnt] = scu_pkg::mk_err(scu_pkg::E_QUOTE);
							cnt      = cnt + 2'd1;
						end
						default: begin
							res[cnt] = scu_pkg::mk_char(char_value);
							cnt      = cnt + 2'd1;
						end
					endcase
				end
				scu_pkg::M_PIPE, scu_pkg::M_AMP, scu_pkg::M_GT: begin
					// first operator char seen: double it or let it go
					if ((mode_q == scu_pkg::M_PIPE && char_value == scu_pkg::CH_PIPE) ||
					    (mode_q == scu_pkg::M_AMP && char_value == scu_pkg::CH_AMP) ||
					    (mode_q == scu_pkg::M_GT && char_value == scu_pkg::CH_GT)) begin
						mode_n   = mode_q + 4'd1;
						res[cnt] = scu_pkg::mk_char(char_value);
						cnt      = cnt + 2'd1;
					end else begin
						mode_n   = scu_pkg::M_INIT;
						res[cnt] = scu_pkg::mk_end((mode_q == scu_pkg::M_PIPE) ? scu_pkg::T_PIPE :
						           (mode_q == scu_pkg::M_AMP) ? scu_pkg::T_BG : scu_pkg::T_GT);
						cnt      = cnt + 2'd1;
						redo     = 1'b1;
					end
				end
				scu_pkg::M_PIPE2, scu_pkg::M_AMP2, scu_pkg::M_GT2: begin
					if ((mode_q == scu_pkg::M_PIPE2 && char_value == scu_pkg::CH_PIPE) ||
					    (mode_q == scu_pkg::M_AMP2 && char_value == scu_pkg::CH_AMP) ||
					    (mode_q == scu_pkg::M_GT2 && char_value == scu_pkg::CH_GT)) begin
						mode_n   = scu_pkg::M_ERROR;
						err_n    = scu_pkg::E_TRIPLE;
						res[cnt] = scu_pkg::mk_err(scu_pkg::E_TRIPLE);
						cnt      = cnt + 2'd1;
					end else begin
						mode_n   = scu_pkg::M_INIT;
						res[cnt] = scu_pkg::mk_end((mode_q == scu_pkg::M_PIPE2) ? scu_pkg::T_OR :
						           (mode_q == scu_pkg::M_AMP2) ? scu_pkg::T_AND : scu_pkg::T_GT2);
						cnt      = cnt + 2'd1;
						redo     = 1'b1;
					end
				end
				default: begin
					// error, done: ignore the byte
				end
			endcase

			// handle the byte again from the initial mode
			if (redo) begin
				case (char_value) inside
					scu_pkg::CH_SPACE, scu_pkg::CH_TAB: begin
					end
					scu_pkg::CH_LT, scu_pkg::CH_SEMI, scu_pkg::CH_LPAREN, scu_pkg::CH_RPAREN: begin
						res[cnt] = scu_pkg::mk_char(char_value);
						cnt      = cnt + 2'd1;
						res[cnt] = scu_pkg::mk_end((char_value == scu_pkg::CH_LT) ? scu_pkg::T_LT :
						           (char_value == scu_pkg::CH_SEMI) ? scu_pkg::T_SEMI :
						           scu_pkg::T_PAREN);
						cnt      = cnt + 2'd1;
					end
					scu_pkg::CH_NL: begin
						mode_n   = scu_pkg::M_DONE;
						res[cnt] = scu_pkg::mk_line();
						cnt      = cnt + 2'd1;
					end
					scu_pkg::CH_BSLASH: mode_n = scu_pkg::M_WESC;
					scu_pkg::CH_DQUOTE: mode_n = scu_pkg::M_STR;
					default: begin
						mode_n   = (char_value == scu_pkg::CH_PIPE) ? scu_pkg::M_PIPE :
						           (char_value == scu_pkg::CH_AMP)  ? scu_pkg::M_AMP  :
						           (char_value == scu_pkg::CH_GT)   ? scu_pkg::M_GT   :
						           scu_pkg::M_WORD;
						res[cnt] = scu_pkg::mk_char(char_value);
						cnt      = cnt + 2'd1;
					end
				endcase
			end
		end
	end

	assign step.res   = res;
	assign step.count = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= scu_pkg::M_INIT;
			err_q  <= scu_pkg::E_NONE;
		end else if (fire) begin
			mode_q <= mode_n;
			err_q  <= err_n;
		end
	end

	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != scu_pkg::E_NONE |-> mode_q == scu_pkg::M_ERROR)
		else $error("error code held outside error mode");

	a_mode_err: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == scu_pkg::M_ERROR |-> err_q != scu_pkg::E_NONE)
		else $error("error mode without error code");

endmodule

FILE: rtl/scu_result_queue.sv
module scu_result_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  scu_pkg::step_t  step,
	output logic            free,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	scu_pkg::result_t [scu_pkg::MAX_RES-1:0] res_q;
	scu_pkg::result_t res_head;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       busy;
	logic       take;

	assign busy     = cnt_q != 2'd0;
	assign m_tvalid = busy;
	assign res_head = res_q[idx_q];
	assign m_tdata  = {2'b00, res_head.error_code, res_head.token_type, res_head.token_char};
	assign m_tuser  = res_head.kind;
	assign m_tlast  = idx_q == (cnt_q - 2'd1);
	assign take     = busy && m_tready;
	// room for the next item's results once the final word leaves
	assign free     = !busy || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load && step.count != 2'd0) begin
			cnt_q <= step.count;
			idx_q <= 2'd0;
		end else if (take) begin
			if (m_tlast) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && step.count != 2'd0) begin
			res_q <= step.res;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> idx_q < cnt_q)
		else $error("result index beyond result count");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take && m_tlast && !(load && step.count != 2'd0) |=> !m_tvalid)
		else $error("queue still valid after final word");

endmodule
